[hdl/wildcard_byte_pattern_search_macros.svh]
// Assertion macros shared by the search block.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

`define WBPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps assertion failed");

`define WBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps assertion failed");

`else

`define WBPS_ASSERT_NOW(label, ante, cons)

`define WBPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/wbps_pkg.sv]
package wbps_pkg;

    localparam int REG_PATTERN_MAX = 16;
    localparam int LEN_BITS        = 5;
    localparam int ADDR_FIELD_BITS = 48;
    localparam int APB_ADDR_BITS   = 6;
    localparam int APB_DATA_BITS   = 64;
    localparam int REG_INDEX_BITS  = 3;

    localparam logic [REG_INDEX_BITS-1:0] REG_PAT_0_3   = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_PAT_4_7   = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_PAT_8_11  = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_PAT_12_15 = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_WILD_MASK = 3'd4;
    localparam logic [REG_INDEX_BITS-1:0] REG_PAT_LEN   = 3'd5;
    localparam logic [REG_INDEX_BITS-1:0] REG_BASE      = 3'd6;

    typedef struct packed {
        logic [REG_PATTERN_MAX-1:0][7:0] pattern;
        logic [REG_PATTERN_MAX-1:0]      wild_mask;
        logic [LEN_BITS-1:0]             pattern_length;
        logic [ADDR_FIELD_BITS-1:0]      region_base;
    } cfg_t;

endpackage

[hdl/wbps_regs.sv]
module wbps_regs
    import wbps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output cfg_t                     cfg
);

    logic [REG_PATTERN_MAX-1:0][7:0] pattern_reg;
    logic [REG_PATTERN_MAX-1:0]      wild_mask_reg;
    logic [LEN_BITS-1:0]             pattern_length_reg;
    logic [ADDR_FIELD_BITS-1:0]      region_base_reg;
    logic [REG_INDEX_BITS-1:0]       reg_index;
    logic                            write_en;

    assign reg_index = paddr[APB_ADDR_BITS-1:APB_ADDR_BITS-REG_INDEX_BITS];
    assign write_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg        <= '0;
            wild_mask_reg      <= '0;
            pattern_length_reg <= LEN_BITS'(1);
            region_base_reg    <= '0;
        end
        else if (write_en)
        begin
            unique case (reg_index)
                REG_PAT_0_3:   pattern_reg[3:0]   <= pwdata[31:0];
                REG_PAT_4_7:   pattern_reg[7:4]   <= pwdata[31:0];
                REG_PAT_8_11:  pattern_reg[11:8]  <= pwdata[31:0];
                REG_PAT_12_15: pattern_reg[15:12] <= pwdata[31:0];
                REG_WILD_MASK: wild_mask_reg      <= pwdata[REG_PATTERN_MAX-1:0];
                REG_PAT_LEN:   pattern_length_reg <= pwdata[LEN_BITS-1:0];
                REG_BASE:      region_base_reg    <= pwdata[ADDR_FIELD_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_PAT_0_3:   prdata = APB_DATA_BITS'(pattern_reg[3:0]);
            REG_PAT_4_7:   prdata = APB_DATA_BITS'(pattern_reg[7:4]);
            REG_PAT_8_11:  prdata = APB_DATA_BITS'(pattern_reg[11:8]);
            REG_PAT_12_15: prdata = APB_DATA_BITS'(pattern_reg[15:12]);
            REG_WILD_MASK: prdata = APB_DATA_BITS'(wild_mask_reg);
            REG_PAT_LEN:   prdata = APB_DATA_BITS'(pattern_length_reg);
            REG_BASE:      prdata = APB_DATA_BITS'(region_base_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.pattern        = pattern_reg;
    assign cfg.wild_mask      = wild_mask_reg;
    assign cfg.pattern_length = pattern_length_reg;
    assign cfg.region_base    = region_base_reg;

endmodule

[hdl/wbps_match.sv]
module wbps_match
    import wbps_pkg::*;
#(
    parameter int CMP_BYTES = 16
)
(
    input  logic [CMP_BYTES-1:0][7:0]           window,
    input  logic [$clog2(CMP_BYTES+1)-1:0]      fill,
    input  cfg_t                                cfg,
    output logic [LEN_BITS-1:0]                 active_len,
    output logic                                hit
);

    localparam int IDX_BITS = (CMP_BYTES > 1) ? $clog2(CMP_BYTES) : 1;

    // Clamp the configured length to 1..CMP_BYTES
    always_comb
    begin
        if (cfg.pattern_length == '0)
            active_len = LEN_BITS'(1);
        else if (cfg.pattern_length > LEN_BITS'(CMP_BYTES))
            active_len = LEN_BITS'(CMP_BYTES);
        else
            active_len = cfg.pattern_length;
    end

    // Pattern byte i lines up with window entry len-1-i (entry 0 is newest)
    always_comb
    begin
        logic [LEN_BITS-1:0] diff;
        logic [IDX_BITS-1:0] idx;
        logic                all_ok;
        all_ok = 1'b1;
        for (int i = 0; i < CMP_BYTES; i++)
        begin
            diff = active_len - LEN_BITS'(i) - LEN_BITS'(1);
            idx  = diff[IDX_BITS-1:0];
            if ((LEN_BITS'(i) < active_len) && !cfg.wild_mask[i]
                && (window[idx] != cfg.pattern[i]))
                all_ok = 1'b0;
        end
        hit = all_ok && (LEN_BITS'(fill) >= active_len);
    end

endmodule

[hdl/wildcard_byte_pattern_search.sv]
// Channel  | Signals                                   | Accepted when
// ---------+-------------------------------------------+-------------------------------
// in       | in_valid, in_ready, data_byte, last_byte  | in_valid & in_ready
// out      | out_valid, out_ready, found, match_address| out_valid & out_ready
// config   | psel, penable, pwrite, paddr, pwdata      | psel & penable & pwrite & pready
//
// One byte per cycle when out_ready stays high; set by the single compare stage.
// Result path: the input register, then the result register, ahead of out_valid.
// rst_n clears control state and loads register defaults (length 1, rest 0).
// A held result stalls only a byte that makes a result; other bytes keep flowing.
`include "wildcard_byte_pattern_search_macros.svh"

module wildcard_byte_pattern_search
    import wbps_pkg::*;
#(
    parameter int PATTERN_BYTES = 16,
    parameter int ADDR_BITS     = 48
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_BITS-1:0]   paddr,
    input  logic [APB_DATA_BITS-1:0]   pwdata,
    output logic [APB_DATA_BITS-1:0]   prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       found,
    output logic [ADDR_FIELD_BITS-1:0] match_address
);

    localparam int CMP_BYTES = (PATTERN_BYTES < REG_PATTERN_MAX) ?
                               PATTERN_BYTES : REG_PATTERN_MAX;
    localparam int FILL_BITS = $clog2(CMP_BYTES + 1);
    localparam int SUM_BITS  = (ADDR_BITS > ADDR_FIELD_BITS) ? ADDR_BITS : ADDR_FIELD_BITS;
    localparam logic [SUM_BITS-1:0] ADDR_MASK = {SUM_BITS{1'b1}} >> (SUM_BITS - ADDR_BITS);

    cfg_t                          cfg;

    logic                          in_valid_reg;
    logic [7:0]                    data_reg;
    logic                          last_reg;

    logic [CMP_BYTES-1:0][7:0]     window_reg;
    logic [CMP_BYTES-1:0][7:0]     window_next;
    logic [FILL_BITS-1:0]          fill_reg;
    logic [FILL_BITS-1:0]          fill_next;
    logic [ADDR_BITS-1:0]          offset_reg;
    logic                          done_reg;

    logic                          out_valid_reg;
    logic                          found_reg;
    logic [ADDR_FIELD_BITS-1:0]    address_reg;
    logic [ADDR_FIELD_BITS-1:0]    address_next;

    logic [LEN_BITS-1:0]           active_len;
    logic                          hit;
    logic                          advance;
    logic                          produce;
    logic [SUM_BITS-1:0]           sum_full;

    wbps_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    assign advance  = in_valid_reg && (!produce || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Hold the incoming item until the compare stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    always_comb
    begin
        window_next[0] = data_reg;
        for (int k = 1; k < CMP_BYTES; k++)
            window_next[k] = window_reg[k-1];
    end

    assign fill_next = (fill_reg == FILL_BITS'(CMP_BYTES)) ? fill_reg
                                                          : fill_reg + FILL_BITS'(1);

    wbps_match #(.CMP_BYTES(CMP_BYTES)) u_match
    (
        .window     (window_next),
        .fill       (fill_next),
        .cfg        (cfg),
        .active_len (active_len),
        .hit        (hit)
    );

    // Match start = offset - (len - 1), then rebased and wrapped
    assign sum_full = SUM_BITS'(cfg.region_base) + SUM_BITS'(offset_reg)
                      - SUM_BITS'(active_len) + SUM_BITS'(1);
    assign address_next = hit ? ADDR_FIELD_BITS'(sum_full & ADDR_MASK) : '0;

    assign produce = !done_reg && (hit || last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            offset_reg    <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                if (last_reg)
                begin
                    fill_reg   <= '0;
                    offset_reg <= '0;
                    done_reg   <= 1'b0;
                end
                else if (!done_reg)
                begin
                    fill_reg   <= fill_next;
                    offset_reg <= offset_reg + ADDR_BITS'(1);
                    done_reg   <= hit;
                end
            end
            if (advance && produce)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !done_reg)
            window_reg <= window_next;
        if (advance && produce)
        begin
            found_reg   <= hit;
            address_reg <= address_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = address_reg;

    `WBPS_ASSERT_NOW(a_notfound_zero_addr, out_valid_reg && !found_reg, address_reg == '0)
    `WBPS_ASSERT_NEXT(a_restart_on_last, advance && last_reg, !done_reg && fill_reg == '0)
    `WBPS_ASSERT_NEXT(a_match_sets_done, advance && produce && !last_reg, done_reg)
    `WBPS_ASSERT_NOW(a_no_result_after_done, advance && done_reg, !produce)

endmodule

[tb/wildcard_byte_pattern_search_tb.sv]
module wildcard_byte_pattern_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wbps_pkg::*;

    localparam logic [REG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PHASE_ITEMS     = 65;

    typedef struct packed {
        logic                       found;
        logic [ADDR_FIELD_BITS-1:0] match_address;
    } match_result_t;

    typedef logic [7:0] region_bytes_t[$];

    class match_scoreboard;
        logic [8*REG_PATTERN_MAX-1:0] pattern_bits;
        logic [REG_PATTERN_MAX-1:0]   wild_mask;
        logic [LEN_BITS-1:0]          length_reg;
        logic [ADDR_FIELD_BITS-1:0]   base;
        logic [7:0]                   window [REG_PATTERN_MAX];
        int                           fill;
        logic [ADDR_FIELD_BITS-1:0]   offset;
        bit                           done;
        match_result_t                expected_matches[$];
        int                           errors;

        function new();
            pattern_bits = '0;
            wild_mask    = '0;
            length_reg   = LEN_BITS'(1);
            base         = '0;
            errors       = 0;
            restart();
        endfunction

        function void restart();
            foreach (window[i])
                window[i] = '0;
            fill   = 0;
            offset = '0;
            done   = 1'b0;
        endfunction

        function void set_register(logic [REG_INDEX_BITS-1:0] idx, logic [63:0] value);
            case (idx)
                REG_PAT_0_3, REG_PAT_4_7, REG_PAT_8_11, REG_PAT_12_15:
                    pattern_bits[32*idx +: 32] = value[31:0];
                REG_WILD_MASK: wild_mask  = value[REG_PATTERN_MAX-1:0];
                REG_PAT_LEN:   length_reg = value[LEN_BITS-1:0];
                REG_BASE:      base       = value[ADDR_FIELD_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int effective_length();
            if (length_reg == 0)
                return 1;
            if (length_reg > REG_PATTERN_MAX)
                return REG_PATTERN_MAX;
            return length_reg;
        endfunction

        function logic [7:0] pattern_byte(int i);
            return pattern_bits[8*i +: 8];
        endfunction

        function void note_byte(logic [7:0] value, logic is_last);
            int                         len;
            bit                         hit;
            logic [ADDR_FIELD_BITS-1:0] start;
            match_result_t              r;
            if (!done)
            begin
                len   = effective_length();
                start = offset - ADDR_FIELD_BITS'(len - 1);
                for (int i = REG_PATTERN_MAX - 1; i > 0; i--)
                    window[i] = window[i-1];
                window[0] = value;
                if (fill < REG_PATTERN_MAX)
                    fill++;
                offset = offset + 1'b1;
                hit = (fill >= len);
                for (int i = 0; i < len && hit; i++)
                    if (!wild_mask[i] && window[len-1-i] !== pattern_byte(i))
                        hit = 1'b0;
                if (hit)
                begin
                    r.found         = 1'b1;
                    r.match_address = base + start;
                    expected_matches.push_back(r);
                    done = 1'b1;
                end
                else if (is_last)
                begin
                    r.found         = 1'b0;
                    r.match_address = '0;
                    expected_matches.push_back(r);
                end
            end
            if (is_last)
                restart();
        endfunction

        function void check_result(logic got_found, logic [ADDR_FIELD_BITS-1:0] got_address);
            match_result_t want;
            if (expected_matches.size() == 0)
            begin
                $error("result with no item pending: found %0d, match_address %h",
                       got_found, got_address);
                errors++;
                return;
            end
            want = expected_matches.pop_front();
            if (got_found !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, got_found);
                errors++;
            end
            if (got_address !== want.match_address)
            begin
                $error("match_address: expected %h, actual %h", want.match_address, got_address);
                errors++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]   paddr = '0;
    logic [APB_DATA_BITS-1:0]   pwdata = '0;
    logic [APB_DATA_BITS-1:0]   prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [7:0]                 data_byte = '0;
    logic                       last_byte = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       found;
    logic [ADDR_FIELD_BITS-1:0] match_address;

    match_scoreboard sb = new();
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_off_request = 1'b0;
    int bytes_in_phase = 0;
    int idle_cycles = 0;

    wildcard_byte_pattern_search u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_address (match_address)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_byte(data_byte, last_byte);
        if (rst_n && out_valid && out_ready)
            sb.check_result(found, match_address);
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_register(input logic [REG_INDEX_BITS-1:0] idx,
                                  input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic load_search_config(input logic [127:0] pat, input logic [15:0] wild,
                                      input logic [4:0] len, input logic [47:0] base);
        write_register(REG_PAT_0_3,   64'(pat[31:0]));
        write_register(REG_PAT_4_7,   64'(pat[63:32]));
        write_register(REG_PAT_8_11,  64'(pat[95:64]));
        write_register(REG_PAT_12_15, 64'(pat[127:96]));
        write_register(REG_WILD_MASK, 64'(wild));
        write_register(REG_PAT_LEN,   64'(len));
        write_register(REG_BASE,      64'(base));
    endtask

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 64)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= is_last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_in_phase++;
    endtask

    task automatic send_region(input region_bytes_t bytes);
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic send_random_region();
        region_bytes_t bytes;
        int len;
        int rlen;
        int pos;
        int kind;
        int k;
        len  = sb.effective_length();
        rlen = $urandom_range(1, len + 8);
        kind = $urandom_range(99);
        for (int i = 0; i < rlen; i++)
            bytes.push_back(8'($urandom_range(255)));
        if (kind < 75 && rlen >= len)
        begin
            pos = $urandom_range(0, rlen - len);
            for (int i = 0; i < len; i++)
                if (!sb.wild_mask[i])
                    bytes[pos+i] = sb.pattern_byte(i);
            if (kind < 15)
            begin
                k = $urandom_range(0, len - 1);
                if (!sb.wild_mask[k])
                    bytes[pos+k] = ~sb.pattern_byte(k);
            end
        end
        send_region(bytes);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_matches.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int lens [8];
        logic [127:0] pat;
        logic [15:0] wild;
        logic [47:0] base;
        lens = '{1, 16, 0, 31, 5, 17, 2, 9};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_search_config(128'h005A_3FFF, 16'h0002, 5'd3, 48'hFFFF_FFFF_FFFF);
        send_region('{8'h00, 8'hFF, 8'h77, 8'h5A});
        send_region('{8'hFF, 8'h00});
        send_region('{8'h5A});
        send_region('{8'hFF, 8'hAA, 8'h5A, 8'h01, 8'hFF, 8'h00});
        send_region('{8'h00, 8'h80, 8'hFF, 8'h01, 8'h7F});
        drain_block();
        write_register(REG_PAT_LEN, 64'd0);
        write_register(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_region('{8'h12, 8'hFF});

        for (int phase = 0; phase < 8; phase++)
        begin
            drain_block();
            pat = {$urandom, $urandom, $urandom, $urandom};
            if (phase == 0)
                wild = '0;
            else if (phase == 3)
                wild = '1;
            else
                wild = 16'($urandom & $urandom & $urandom);
            if (phase == 0)
                base = '1;
            else if (phase == 1)
                base = '0;
            else
                base = 48'({$urandom, $urandom});
            if (phase == 6)
                lens[phase] = $urandom_range(2, 15);
            load_search_config(pat, wild, 5'(lens[phase]), base);

            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
                default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
            endcase
            if (phase == 4)
                hold_off_request = 1'b1;

            bytes_in_phase = 0;
            while (bytes_in_phase < PHASE_ITEMS)
                send_random_region();
        end

        drain_block();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
